/* hdl/gdad_pkg.sv */
// Shared types, constants and month table for the date adder.
`default_nettype none

package gdad_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int ADD_W   = 16;
    localparam int MOD25_W = 5;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // floor(y / 25) = (y * RECIP25) >> RECIP_SHIFT for every 16-bit y
    localparam int            RECIP_W     = 17;
    localparam int            RECIP_SHIFT = 21;
    localparam logic [16:0]   RECIP25     = 17'd83887;
    localparam int            PROD_W      = YEAR_W + RECIP_W;
    localparam int            QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [MOD25_W-1:0] MOD25_LAST = 5'd24;
    localparam logic [YEAR_W-1:0]  YEAR_LAST  = 16'hFFFF;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [MOD25_W-1:0] mod25;   // year mod 25, for the century rule
    } date_t;

    localparam int DATE_W = $bits(date_t);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } walk_state_t;

    // Month length; codes outside January..December count as 31 days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        begin
            case (month)
                MON_FEB: len = leap ? 5'd29 : 5'd28;
                MON_APR,
                MON_JUN,
                MON_SEP,
                MON_NOV: len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/gdad_queue.sv */
// Small register FIFO between the front stage and the month walker.
`default_nettype none

module gdad_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/gdad_front.sv */
// Front stage: take a request, find year mod 25, hand it to the queue.
`default_nettype none

module gdad_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [gdad_pkg::DAY_W-1:0]   start_day,
    input  wire logic [gdad_pkg::MONTH_W-1:0] start_month,
    input  wire logic [gdad_pkg::YEAR_W-1:0]  start_year,
    input  wire logic [gdad_pkg::ADD_W-1:0]   days_to_add,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output gdad_pkg::date_t                   q_date,
    output logic [COUNT_WIDTH-1:0]            q_count
);

    import gdad_pkg::*;

    localparam int IN_W = (COUNT_WIDTH < ADD_W) ? COUNT_WIDTH : ADD_W;

    logic                   valid_reg, valid_next;
    logic [DAY_W-1:0]       day_reg;
    logic [MONTH_W-1:0]     month_reg;
    logic [YEAR_W-1:0]      year_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   take;
    logic [QUOT_W-1:0]      quot;
    logic [YEAR_W-1:0]      quot25;

    assign in_ready = !valid_reg || q_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // remainder from the registered reciprocal product: y - 25 * floor(y / 25)
    assign quot   = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign quot25 = (YEAR_W'(quot) << 4) + (YEAR_W'(quot) << 3) + YEAR_W'(quot);

    assign q_valid       = valid_reg;
    assign q_date.day    = day_reg;
    assign q_date.month  = month_reg;
    assign q_date.year   = year_reg;
    assign q_date.mod25  = MOD25_W'(year_reg - quot25);
    assign q_count       = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            day_reg   <= start_day;
            month_reg <= start_month;
            year_reg  <= start_year;
            count_reg <= COUNT_WIDTH'(days_to_add[IN_W-1:0]);
            prod_reg  <= PROD_W'(start_year) * PROD_W'(RECIP25);
        end
    end

endmodule

`default_nettype wire

/* hdl/gdad_walk.sv */
// Back stage: walk the date forward one month per cycle, hold the result.
`default_nettype none

module gdad_walk #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    output logic                        q_pop,
    input  wire gdad_pkg::date_t        q_date,
    input  wire logic [COUNT_WIDTH-1:0] q_count,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [gdad_pkg::DAY_W-1:0]   result_day,
    output logic [gdad_pkg::MONTH_W-1:0] result_month,
    output logic [gdad_pkg::YEAR_W-1:0]  result_year
);

    import gdad_pkg::*;

    walk_state_t            state_reg, state_next;
    logic [DAY_W-1:0]       day_reg, day_next;
    logic [MONTH_W-1:0]     month_reg, month_next;
    logic [YEAR_W-1:0]      year_reg, year_next;
    logic [MOD25_W-1:0]     mod25_reg, mod25_next;
    logic [COUNT_WIDTH-1:0] left_reg, left_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]       res_day_reg;
    logic [MONTH_W-1:0]     res_month_reg;
    logic [YEAR_W-1:0]      res_year_reg;

    logic                   leap;
    logic [DAY_W-1:0]       len;
    logic [DAY_W-1:0]       avail;
    logic                   fits;
    logic                   out_free;
    logic                   load;
    logic                   finish;
    logic                   step;

    // leap: divisible by 4, and not by 100 unless by 400 (16 and 25 stand in)
    assign leap     = (year_reg[1:0] == 2'b00) &&
                      ((mod25_reg != '0) || (year_reg[3:0] == 4'b0000));
    assign len      = month_days(month_reg, leap);
    assign avail    = (day_reg <= len) ? (len - day_reg) : '0;
    assign fits     = (left_reg <= COUNT_WIDTH'(avail));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (fits && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        load   = 1'b0;
        finish = 1'b0;
        step   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                load = q_valid;
            end
            ST_WALK:
            begin
                finish = fits && out_free;
                step   = !fits;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    assign q_pop = load;

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        mod25_next = mod25_reg;
        left_next  = left_reg;
        if (load)
        begin
            day_next   = q_date.day;
            month_next = q_date.month;
            year_next  = q_date.year;
            mod25_next = q_date.mod25;
            left_next  = q_count;
        end
        else if (step)
        begin
            // spend the rest of this month, then land on day 1 of the next
            left_next = left_reg - COUNT_WIDTH'({1'b0, avail} + 6'd1);
            day_next  = 5'd1;
            if (month_reg >= MON_DEC)
            begin
                month_next = MON_JAN;
                year_next  = year_reg + 1'b1;
                if (year_reg == YEAR_LAST || mod25_reg == MOD25_LAST)
                begin
                    mod25_next = '0;
                end
                else
                begin
                    mod25_next = mod25_reg + 1'b1;
                end
            end
            else
            begin
                month_next = month_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        mod25_reg <= mod25_next;
        left_reg  <= left_next;
        if (finish)
        begin
            res_day_reg   <= day_reg + DAY_W'(left_reg);
            res_month_reg <= month_reg;
            res_year_reg  <= year_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_day   = res_day_reg;
    assign result_month = res_month_reg;
    assign result_year  = res_year_reg;

    a_left_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && !fits) |=> (left_reg < $past(left_reg)))
        else $error("remaining count did not shrink on a month step");

    a_step_lands_day1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && !fits) |=>
        (day_reg == 5'd1 && month_reg >= MON_JAN && month_reg <= MON_DEC))
        else $error("month step left an invalid date");

    a_mod25_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (mod25_reg <= MOD25_LAST))
        else $error("year mod 25 tracker out of range");

    a_finish_posts: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished walk did not post a result");

endmodule

`default_nettype wire

/* hdl/gregorian_date_add_days_unit.sv */
// Top level of the date adder: front stage, queue and month walker.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  start date and day count
//  m_axis    out  m_axis_tvalid / m_axis_tready  resulting date
//
// A request is registered in the front stage (year mod 25 from a reciprocal
// multiply), then waits in the queue. The walker loads it and crosses one
// month per cycle; it takes a new request only once the last result is posted,
// so the walker loop sets the rate. Reset clears all valid state.
// Either side may stall: the queue and the output register keep the two sides apart.
`default_nettype none

module gregorian_date_add_days_unit #(
    parameter int COUNT_WIDTH = gdad_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = gdad_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] start_day, [8:5] start_month, [24:9] start_year, [40:25] days_to_add
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] result_day, [8:5] result_month, [24:9] result_year
    output logic [31:0]      m_axis_tdata
);

    import gdad_pkg::*;

    localparam int Q_W = COUNT_WIDTH + DATE_W;

    logic                   f_valid;
    logic                   f_ready;
    date_t                  f_date;
    logic [COUNT_WIDTH-1:0] f_count;
    logic                   q_valid;
    logic                   q_pop;
    logic [Q_W-1:0]         q_data;
    date_t                  w_date;
    logic [COUNT_WIDTH-1:0] w_count;
    logic [DAY_W-1:0]       res_day;
    logic [MONTH_W-1:0]     res_month;
    logic [YEAR_W-1:0]      res_year;

    gdad_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .start_day   (s_axis_tdata[4:0]),
        .start_month (s_axis_tdata[8:5]),
        .start_year  (s_axis_tdata[24:9]),
        .days_to_add (s_axis_tdata[40:25]),
        .q_valid     (f_valid),
        .q_ready     (f_ready),
        .q_date      (f_date),
        .q_count     (f_count)
    );

    gdad_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_count, f_date}),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_data  (q_data)
    );

    assign w_date  = q_data[DATE_W-1:0];
    assign w_count = q_data[Q_W-1:DATE_W];

    gdad_walk #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_date       (w_date),
        .q_count      (w_count),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .result_day   (res_day),
        .result_month (res_month),
        .result_year  (res_year)
    );

    assign m_axis_tdata = {7'b0, res_year, res_month, res_day};

endmodule

`default_nettype wire

/* verif/gregorian_date_add_days_unit_tb.sv */
// Self-checking testbench for the date adder: corner table, then random requests.
`timescale 1ns / 100ps
`default_nettype none

module gregorian_date_add_days_unit_tb;

    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 64;
    localparam int PHASE_ITEMS  = 450;
    localparam int REPORT_LIMIT = 10;
    localparam int CORNER_ROWS  = 20;

    typedef struct packed {
        logic [gdad_pkg::DAY_W-1:0]   day;
        logic [gdad_pkg::MONTH_W-1:0] month;
        logic [gdad_pkg::YEAR_W-1:0]  year;
    } cal_date_t;

    typedef struct packed {
        cal_date_t                  start;
        logic [gdad_pkg::ADD_W-1:0] count;
        logic                       known;   // expected date typed in below
        cal_date_t                  result;
    } corner_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    cal_date_t   pending_dates [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap_pct = 16;
    int unsigned take_gap_pct = 46;

    corner_row_t corner_rows [CORNER_ROWS] = '{
        '{'{5'd1,  4'd1,  16'd0},     16'd0,     1'b1, '{5'd1,  4'd1,  16'd0}},
        '{'{5'd0,  4'd15, 16'hFFFF},  16'd0,     1'b1, '{5'd0,  4'd15, 16'hFFFF}},
        '{'{5'd31, 4'd0,  16'd1234},  16'd0,     1'b1, '{5'd31, 4'd0,  16'd1234}},
        '{'{5'd31, 4'd12, 16'hFFFF},  16'd1,     1'b1, '{5'd1,  4'd1,  16'd0}},
        '{'{5'd28, 4'd2,  16'd2000},  16'd1,     1'b1, '{5'd29, 4'd2,  16'd2000}},
        '{'{5'd28, 4'd2,  16'd1900},  16'd1,     1'b1, '{5'd1,  4'd3,  16'd1900}},
        '{'{5'd28, 4'd2,  16'd2024},  16'd1,     1'b1, '{5'd29, 4'd2,  16'd2024}},
        '{'{5'd28, 4'd2,  16'd2023},  16'd1,     1'b1, '{5'd1,  4'd3,  16'd2023}},
        '{'{5'd31, 4'd2,  16'd2001},  16'd1,     1'b1, '{5'd1,  4'd3,  16'd2001}},
        '{'{5'd0,  4'd3,  16'd2001},  16'd1,     1'b1, '{5'd1,  4'd3,  16'd2001}},
        '{'{5'd31, 4'd13, 16'd5},     16'd1,     1'b1, '{5'd1,  4'd1,  16'd6}},
        '{'{5'd31, 4'd15, 16'd9},     16'd1,     1'b1, '{5'd1,  4'd1,  16'd10}},
        '{'{5'd1,  4'd3,  16'd2100},  16'd30,    1'b1, '{5'd31, 4'd3,  16'd2100}},
        '{'{5'd31, 4'd0,  16'd7},     16'd1,     1'b0, '0},
        '{'{5'd1,  4'd1,  16'd0},     16'hFFFF,  1'b0, '0},
        '{'{5'd31, 4'd15, 16'hFFFF},  16'hFFFF,  1'b0, '0},
        '{'{5'd31, 4'd12, 16'hFFFF},  16'hFFFF,  1'b0, '0},
        '{'{5'd1,  4'd1,  16'd1999},  16'd366,   1'b0, '0},
        '{'{5'd15, 4'd6,  16'd2024},  16'd200,   1'b0, '0},
        '{'{5'd29, 4'd2,  16'd2400},  16'd365,   1'b0, '0}
    };

    gregorian_date_add_days_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    function automatic int unsigned days_in_month(logic [gdad_pkg::MONTH_W-1:0] month,
                                                  logic [gdad_pkg::YEAR_W-1:0] year);
        bit leap;
        leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
        case (month)
            gdad_pkg::MON_FEB: return leap ? 29 : 28;
            gdad_pkg::MON_APR,
            gdad_pkg::MON_JUN,
            gdad_pkg::MON_SEP,
            gdad_pkg::MON_NOV: return 30;
            default:           return 31;
        endcase
    endfunction

    // Walk one month at a time; months outside January..December count 31 days,
    // a day past month end leaves no room.
    function automatic cal_date_t walk_calendar(cal_date_t from,
                                                logic [gdad_pkg::ADD_W-1:0] count);
        cal_date_t   at;
        int unsigned left;
        int unsigned len;
        int unsigned room;
        at = from;
        left = count;
        while (left != 0)
        begin
            len = days_in_month(at.month, at.year);
            room = (at.day <= len) ? len - at.day : 0;
            if (left <= room)
            begin
                at.day = at.day + left;
                left = 0;
            end
            else
            begin
                left = left - room - 1;
                at.day = 1;
                if (at.month >= gdad_pkg::MON_DEC)
                begin
                    at.month = gdad_pkg::MON_JAN;
                    at.year = at.year + 1'b1;
                end
                else
                begin
                    at.month = at.month + 1'b1;
                end
            end
        end
        return at;
    endfunction

    // Keep tvalid high across back-to-back requests; drop it only while idling.
    task automatic send_request(cal_date_t start, logic [gdad_pkg::ADD_W-1:0] count,
                                cal_date_t result);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, count, start.year, start.month, start.day};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_dates.push_back(result);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_date(logic [31:0] data);
        cal_date_t got;
        cal_date_t want;
        got = '{data[4:0], data[8:5], data[24:9]};
        if (pending_dates.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result %0d/%0d/%0d", got.day, got.month, got.year);
        end
        else
        begin
            want = pending_dates.pop_front();
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             want.day, want.month, want.year, got.day, got.month, got.year);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_date(m_axis_tdata);
    end

    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= take_gap_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("gregorian_date_add_days_unit_tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        cal_date_t                  start;
        cal_date_t                  result;
        logic [gdad_pkg::ADD_W-1:0] count;
        int unsigned                pick;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_rows[i])
        begin
            result = corner_rows[i].known ? corner_rows[i].result
                                          : walk_calendar(corner_rows[i].start,
                                                          corner_rows[i].count);
            send_request(corner_rows[i].start, corner_rows[i].count, result);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            // Hold off until the block has emptied before changing the idle mix.
            wait_drained();
            case (phase)
                0:
                begin
                    send_gap_pct = 16;
                    take_gap_pct = 46;
                end
                1:
                begin
                    send_gap_pct = 46;
                    take_gap_pct = 16;
                end
                default:
                begin
                    send_gap_pct = 0;
                    take_gap_pct = 0;
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                    start.year = $urandom_range(0, 655) * 100;
                else if (pick < 25)
                    start.year = 16'hFFFF - $urandom_range(0, 3);
                else
                    start.year = $urandom;
                if ($urandom_range(99) < 80)
                begin
                    start.month = $urandom_range(1, 12);
                    start.day = $urandom_range(1, days_in_month(start.month, start.year));
                end
                else
                begin
                    start.month = $urandom_range(0, 15);
                    start.day = $urandom_range(0, 31);
                end
                // Keep most spans short; only a few cross thousands of months.
                pick = $urandom_range(99);
                if (pick < 70)
                    count = $urandom_range(0, 120);
                else if (pick < 90)
                    count = $urandom_range(0, 2000);
                else
                    count = $urandom;
                send_request(start, count, walk_calendar(start, count));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("gregorian_date_add_days_unit_tb: PASS");
        else
            $display("gregorian_date_add_days_unit_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
